[rtl/adaptive_huffman_tree_update_macros.svh]
// Assertion macros for the adaptive Huffman tree update RTL.
// Included by the module that carries the concurrent assertions.
`ifndef ADAPTIVE_HUFFMAN_TREE_UPDATE_MACROS_SVH
`define ADAPTIVE_HUFFMAN_TREE_UPDATE_MACROS_SVH

// Condition a implies c at the same clock edge.
`define AHTU_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("adaptive huffman tree update: assertion failed");

// Condition a implies c at the following clock edge.
`define AHTU_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("adaptive huffman tree update: assertion failed");

`endif

[rtl/ahtu_pkg.sv]
// Package for the adaptive Huffman tree update block.
// Holds link widths, status codes, the node write-enable struct and helpers.
`default_nettype none

package ahtu_pkg;

  localparam int LINK_W    = 10;
  localparam int RANK_W    = 10;
  localparam int SYM_W     = 8;
  localparam int PATH_BITS = 256;
  localparam int PLEN_W    = 9;
  localparam int CHUNK_W   = 64;

  localparam logic [LINK_W-1:0] NO_NODE  = 10'h3FF;
  localparam logic [RANK_W-1:0] TOP_RANK = 10'd512;

  localparam logic [2:0] ST_PRESENT  = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic weight;
    logic rank;
    logic up;
    logic left;
    logic right;
  } node_we_t;

  function automatic logic [CHUNK_W-1:0] rev64(input logic [CHUNK_W-1:0] v);
    logic [CHUNK_W-1:0] r;
    for (int i = 0; i < CHUNK_W; i++) begin
      r[i] = v[CHUNK_W-1-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ahtu_node_mem.sv]
// Node table of the adaptive Huffman tree: weight, rank and link memories.
// One shared read address with registered data, one write address with per-field enables.
`default_nettype none

module ahtu_node_mem import ahtu_pkg::*; #(
  parameter int MAX_NODES   = 513,
  parameter int WEIGHT_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic [LINK_W-1:0]      rd_addr,
  output logic [WEIGHT_BITS-1:0]      rd_weight,
  output logic [RANK_W-1:0]           rd_rank,
  output logic [LINK_W-1:0]           rd_up,
  output logic [LINK_W-1:0]           rd_left,
  output logic [LINK_W-1:0]           rd_right,
  input  wire node_we_t               wr_en,
  input  wire logic [LINK_W-1:0]      wr_addr,
  input  wire logic [WEIGHT_BITS-1:0] wr_weight,
  input  wire logic [RANK_W-1:0]      wr_rank,
  input  wire logic [LINK_W-1:0]      wr_up,
  input  wire logic [LINK_W-1:0]      wr_left,
  input  wire logic [LINK_W-1:0]      wr_right
);

  localparam int AW = $clog2(MAX_NODES);

  logic [WEIGHT_BITS-1:0] mem_weight [MAX_NODES];
  logic [RANK_W-1:0]      mem_rank   [MAX_NODES];
  logic [LINK_W-1:0]      mem_up     [MAX_NODES];
  logic [LINK_W-1:0]      mem_left   [MAX_NODES];
  logic [LINK_W-1:0]      mem_right  [MAX_NODES];

  logic wr_ok;
  assign wr_ok = (wr_addr < LINK_W'(MAX_NODES));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      if (wr_en.weight) mem_weight[wr_addr[AW-1:0]] <= wr_weight;
      if (wr_en.rank)   mem_rank[wr_addr[AW-1:0]]   <= wr_rank;
      if (wr_en.up)     mem_up[wr_addr[AW-1:0]]     <= wr_up;
      if (wr_en.left)   mem_left[wr_addr[AW-1:0]]   <= wr_left;
      if (wr_en.right)  mem_right[wr_addr[AW-1:0]]  <= wr_right;
    end
    rd_weight <= mem_weight[rd_addr[AW-1:0]];
    rd_rank   <= mem_rank[rd_addr[AW-1:0]];
    rd_up     <= mem_up[rd_addr[AW-1:0]];
    rd_left   <= mem_left[rd_addr[AW-1:0]];
    rd_right  <= mem_right[rd_addr[AW-1:0]];
  end

endmodule

`default_nettype wire

[rtl/adaptive_huffman_tree_update.sv]
// Adaptive Huffman (FGK style) tree update: one byte symbol in, one to four path chunks out.
// A small sequencer drives the node table in ahtu_node_mem over one read and one write port.
// After reset the block runs a clearing pass over the symbol table and
// accepts no symbol until it ends. Each symbol is then handled one at a time: the
// code path is traced one tree level at a time, and the count update at each
// level scans every used node, plus an ancestry walk for nodes that tie the
// current node's weight and outrank the leader found so far. The time a symbol
// takes grows with the size and depth of the tree, set by the node scan and walks
// through the single node-table read port. Results leave through an output
// register, one chunk per transfer.
`default_nettype none

module adaptive_huffman_tree_update import ahtu_pkg::*; #(
  parameter int MAX_NODES   = 513,
  parameter int WEIGHT_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [SYM_W-1:0]   symbol,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              status,
  output logic [CHUNK_W-1:0]      path_chunk,
  output logic [6:0]              chunk_bits,
  output logic                    last_chunk
);

`include "adaptive_huffman_tree_update_macros.svh"

  localparam logic [WEIGHT_BITS-1:0] WMAX   = {WEIGHT_BITS{1'b1}};
  localparam logic [LINK_W-1:0]      MAXN   = LINK_W'(MAX_NODES);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_LOOK  = 5'd2;
  localparam logic [4:0] S_LOOK1 = 5'd3;
  localparam logic [4:0] S_TR    = 5'd4;
  localparam logic [4:0] S_TR1   = 5'd5;
  localparam logic [4:0] S_TR2   = 5'd6;
  localparam logic [4:0] S_ROOT  = 5'd7;
  localparam logic [4:0] S_ROOT1 = 5'd8;
  localparam logic [4:0] S_SPL0  = 5'd9;
  localparam logic [4:0] S_SPL1  = 5'd10;
  localparam logic [4:0] S_SPL2  = 5'd11;
  localparam logic [4:0] S_SPL3  = 5'd12;
  localparam logic [4:0] S_CU0   = 5'd13;
  localparam logic [4:0] S_CU1   = 5'd14;
  localparam logic [4:0] S_BT    = 5'd15;
  localparam logic [4:0] S_BT1   = 5'd16;
  localparam logic [4:0] S_BT2   = 5'd17;
  localparam logic [4:0] S_BT3   = 5'd18;
  localparam logic [4:0] S_WK    = 5'd19;
  localparam logic [4:0] S_WK1   = 5'd20;
  localparam logic [4:0] S_XCH   = 5'd21;
  localparam logic [4:0] S_X1    = 5'd22;
  localparam logic [4:0] S_X2    = 5'd23;
  localparam logic [4:0] S_X3    = 5'd24;
  localparam logic [4:0] S_X5    = 5'd25;
  localparam logic [4:0] S_X6    = 5'd26;
  localparam logic [4:0] S_X7    = 5'd27;
  localparam logic [4:0] S_INC   = 5'd28;
  localparam logic [4:0] S_EMIT  = 5'd29;

  logic [4:0]             state;
  logic [4:0]             w_ret;
  logic [7:0]             clr_cnt;
  logic [SYM_W-1:0]       sym;
  logic [LINK_W-1:0]      nodes_used;
  logic [LINK_W-1:0]      esc;
  logic [LINK_W-1:0]      tr_n;
  logic [LINK_W-1:0]      tr_child;
  logic [LINK_W-1:0]      start_n;
  logic [LINK_W-1:0]      cu_n;
  logic [LINK_W-1:0]      un;
  logic [LINK_W-1:0]      pb;
  logic [LINK_W-1:0]      best;
  logic [LINK_W-1:0]      c;
  logic [LINK_W-1:0]      steps;
  logic [LINK_W-1:0]      w_anc;
  logic [LINK_W-1:0]      w_cur;
  logic [LINK_W-1:0]      w_steps;
  logic [RANK_W-1:0]      rn;
  logic [RANK_W-1:0]      lr;
  logic [RANK_W-1:0]      best_rank;
  logic [RANK_W-1:0]      cand_rank;
  logic [WEIGHT_BITS-1:0] wn;
  logic [PATH_BITS-1:0]   path;
  logic [PLEN_W-1:0]      plen;
  logic [2:0]             res_status;
  logic                   w_res;
  logic                   is_new;
  logic                   moved;
  logic                   sib;

  // Symbol-to-leaf table.
  logic [LINK_W-1:0] sym_tab [256];
  logic [LINK_W-1:0] sym_rd;
  logic              sym_we;
  logic [SYM_W-1:0]  sym_waddr;
  logic [LINK_W-1:0] sym_wdata;

  // Node table port.
  logic [LINK_W-1:0]      rd_addr;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic [RANK_W-1:0]      rd_rank;
  logic [LINK_W-1:0]      rd_up;
  logic [LINK_W-1:0]      rd_left;
  logic [LINK_W-1:0]      rd_right;
  node_we_t               wr_en;
  logic [LINK_W-1:0]      wr_addr;
  logic [WEIGHT_BITS-1:0] wr_weight;
  logic [RANK_W-1:0]      wr_rank;
  logic [LINK_W-1:0]      wr_up;
  logic [LINK_W-1:0]      wr_left;
  logic [LINK_W-1:0]      wr_right;

  ahtu_node_mem #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_mem (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .rd_weight (rd_weight),
    .rd_rank   (rd_rank),
    .rd_up     (rd_up),
    .rd_left   (rd_left),
    .rd_right  (rd_right),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_weight (wr_weight),
    .wr_rank   (wr_rank),
    .wr_up     (wr_up),
    .wr_left   (wr_left),
    .wr_right  (wr_right)
  );

  always_ff @(posedge clk) begin
    if (sym_we) sym_tab[sym_waddr] <= sym_wdata;
    sym_rd <= sym_tab[sym];
  end

  assign in_stall = (state != S_IDLE);

  logic sib_ok;
  logic skip_c;
  logic emit_fire;
  assign sib_ok = (rd_left == cu_n && rd_right == best) || (rd_left == best && rd_right == cu_n);
  assign skip_c = (c == cu_n) || (c == un) || (rd_weight != wn) || (rd_rank <= best_rank);
  assign emit_fire = (state == S_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    rd_addr   = '0;
    wr_en     = '0;
    wr_addr   = '0;
    wr_weight = '0;
    wr_rank   = '0;
    wr_up     = NO_NODE;
    wr_left   = NO_NODE;
    wr_right  = NO_NODE;
    sym_we    = 1'b0;
    sym_waddr = sym;
    sym_wdata = NO_NODE;
    case (state)
      S_CLR: begin
        sym_we    = 1'b1;
        sym_waddr = clr_cnt;
        if (clr_cnt == 8'd0) begin
          wr_en   = '{weight: 1'b1, rank: 1'b1, up: 1'b1, left: 1'b1, right: 1'b1};
          wr_rank = TOP_RANK;
        end
      end
      S_TR:   rd_addr = tr_n;
      S_TR1:  rd_addr = rd_up;
      S_SPL0: rd_addr = esc;
      S_SPL1: begin
        wr_en     = '{weight: 1'b1, rank: 1'b0, up: 1'b0, left: 1'b1, right: 1'b1};
        wr_addr   = esc;
        wr_weight = WEIGHT_BITS'(1);
        wr_left   = nodes_used + LINK_W'(1);
        wr_right  = nodes_used;
      end
      S_SPL2: begin
        wr_en     = '{weight: 1'b1, rank: 1'b1, up: 1'b1, left: 1'b1, right: 1'b1};
        wr_addr   = nodes_used;
        wr_weight = WEIGHT_BITS'(1);
        wr_rank   = lr - RANK_W'(1);
        wr_up     = esc;
      end
      S_SPL3: begin
        wr_en     = '{weight: 1'b1, rank: 1'b1, up: 1'b1, left: 1'b1, right: 1'b1};
        wr_addr   = nodes_used + LINK_W'(1);
        wr_rank   = lr - RANK_W'(2);
        wr_up     = esc;
        sym_we    = 1'b1;
        sym_wdata = nodes_used;
      end
      S_CU0: rd_addr = cu_n;
      S_BT:  rd_addr = c;
      S_WK:  rd_addr = w_cur;
      S_XCH: rd_addr = best;
      S_X1:  rd_addr = un;
      S_X2: begin
        if (sib_ok) begin
          wr_en    = '{weight: 1'b0, rank: 1'b0, up: 1'b0, left: 1'b1, right: 1'b1};
          wr_addr  = un;
          wr_left  = rd_right;
          wr_right = rd_left;
        end
      end
      S_X3: begin
        rd_addr = pb;
        wr_addr = un;
        wr_left = best;
        wr_right = best;
        if (rd_left == cu_n) wr_en.left = 1'b1;
        else if (rd_right == cu_n) wr_en.right = 1'b1;
      end
      S_X5: begin
        wr_addr  = pb;
        wr_left  = cu_n;
        wr_right = cu_n;
        if (rd_left == best) wr_en.left = 1'b1;
        else if (rd_right == best) wr_en.right = 1'b1;
      end
      S_X6: begin
        wr_en.rank = 1'b1;
        wr_en.up   = !sib;
        wr_addr    = cu_n;
        wr_rank    = best_rank;
        wr_up      = pb;
      end
      S_X7: begin
        wr_en.rank = 1'b1;
        wr_en.up   = !sib;
        wr_addr    = best;
        wr_rank    = rn;
        wr_up      = un;
      end
      S_INC: begin
        wr_en.weight = 1'b1;
        wr_addr      = cu_n;
        wr_weight    = (wn == WMAX) ? wn : wn + WEIGHT_BITS'(1);
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      nodes_used <= LINK_W'(1);
      esc        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !emit_fire) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 8'd1;
          if (clr_cnt == 8'd255) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            sym   <= symbol;
            path  <= '0;
            plen  <= '0;
            state <= S_LOOK;
          end
        end
        S_LOOK: state <= S_LOOK1;
        S_LOOK1: begin
          if (sym_rd != NO_NODE) begin
            is_new  <= 1'b0;
            tr_n    <= sym_rd;
            start_n <= sym_rd;
            state   <= S_TR;
          end else if ({1'b0, nodes_used} + (LINK_W+1)'(2) > (LINK_W+1)'(MAX_NODES)) begin
            res_status <= ST_FULL;
            state      <= S_EMIT;
          end else if (!(esc < nodes_used)) begin
            res_status <= ST_INVALID;
            state      <= S_EMIT;
          end else begin
            is_new  <= 1'b1;
            tr_n    <= esc;
            start_n <= esc;
            state   <= S_TR;
          end
        end
        S_TR: begin
          if (tr_n == '0) begin
            state <= S_ROOT;
          end else if (!(tr_n < nodes_used) || plen == PLEN_W'(PATH_BITS)) begin
            res_status <= ST_INVALID;
            path       <= '0;
            plen       <= '0;
            state      <= S_EMIT;
          end else begin
            state <= S_TR1;
          end
        end
        S_TR1: begin
          if (!(rd_up < nodes_used)) begin
            res_status <= ST_INVALID;
            path       <= '0;
            plen       <= '0;
            state      <= S_EMIT;
          end else begin
            tr_child <= tr_n;
            tr_n     <= rd_up;
            state    <= S_TR2;
          end
        end
        S_TR2: begin
          if (rd_left == tr_child || rd_right == tr_child) begin
            path  <= {path[PATH_BITS-2:0], (rd_left != tr_child)};
            plen  <= plen + PLEN_W'(1);
            state <= S_TR;
          end else begin
            res_status <= ST_INVALID;
            path       <= '0;
            plen       <= '0;
            state      <= S_EMIT;
          end
        end
        S_ROOT: state <= S_ROOT1;
        S_ROOT1: begin
          if (rd_weight == WMAX) begin
            res_status <= ST_OVERFLOW;
            path       <= '0;
            plen       <= '0;
            state      <= S_EMIT;
          end else if (is_new) begin
            res_status <= ST_NEW;
            state      <= S_SPL0;
          end else begin
            res_status <= ST_PRESENT;
            cu_n       <= start_n;
            steps      <= '0;
            state      <= S_CU0;
          end
        end
        S_SPL0: state <= S_SPL1;
        S_SPL1: begin
          un    <= rd_up;
          lr    <= rd_rank;
          state <= S_SPL2;
        end
        S_SPL2: state <= S_SPL3;
        S_SPL3: begin
          esc        <= nodes_used + LINK_W'(1);
          nodes_used <= nodes_used + LINK_W'(2);
          cu_n       <= un;
          steps      <= '0;
          state      <= S_CU0;
        end
        S_CU0: begin
          if (steps > MAXN || !(cu_n < nodes_used)) state <= S_EMIT;
          else state <= S_CU1;
        end
        S_CU1: begin
          wn        <= rd_weight;
          un        <= rd_up;
          rn        <= rd_rank;
          best      <= cu_n;
          best_rank <= rd_rank;
          c         <= '0;
          state     <= S_BT;
        end
        S_BT: begin
          if (c < nodes_used) state <= S_BT1;
          else state <= S_XCH;
        end
        S_BT1: begin
          if (skip_c) begin
            c     <= c + LINK_W'(1);
            state <= S_BT;
          end else begin
            // Candidate outranks the current leader; rule out ancestry both ways.
            cand_rank <= rd_rank;
            w_anc     <= c;
            w_cur     <= cu_n;
            w_steps   <= '0;
            w_ret     <= S_BT2;
            state     <= S_WK;
          end
        end
        S_BT2: begin
          if (w_res) begin
            c     <= c + LINK_W'(1);
            state <= S_BT;
          end else begin
            w_anc   <= cu_n;
            w_cur   <= c;
            w_steps <= '0;
            w_ret   <= S_BT3;
            state   <= S_WK;
          end
        end
        S_BT3: begin
          if (!w_res) begin
            best      <= c;
            best_rank <= cand_rank;
          end
          c     <= c + LINK_W'(1);
          state <= S_BT;
        end
        S_WK: begin
          if (w_cur == NO_NODE || w_steps > MAXN) begin
            w_res <= 1'b0;
            state <= w_ret;
          end else if (w_cur == w_anc) begin
            w_res <= 1'b1;
            state <= w_ret;
          end else if (!(w_cur < nodes_used)) begin
            w_res <= 1'b0;
            state <= w_ret;
          end else begin
            w_steps <= w_steps + LINK_W'(1);
            state   <= S_WK1;
          end
        end
        S_WK1: begin
          w_cur <= rd_up;
          state <= S_WK;
        end
        S_XCH: begin
          if (best == cu_n) begin
            moved <= 1'b0;
            state <= S_INC;
          end else begin
            state <= S_X1;
          end
        end
        S_X1: begin
          pb <= rd_up;
          if (!(un < nodes_used) || !(rd_up < nodes_used)) state <= S_EMIT;
          else if (un == rd_up) state <= S_X2;
          else state <= S_X3;
        end
        S_X2: begin
          if (sib_ok) begin
            sib   <= 1'b1;
            moved <= 1'b0;
            state <= S_X6;
          end else begin
            state <= S_EMIT;
          end
        end
        S_X3: begin
          // A failed relink stops counting with any earlier relink kept.
          if (rd_left == cu_n || rd_right == cu_n) state <= S_X5;
          else state <= S_EMIT;
        end
        S_X5: begin
          if (rd_left == best || rd_right == best) begin
            sib   <= 1'b0;
            moved <= 1'b1;
            state <= S_X6;
          end else begin
            state <= S_EMIT;
          end
        end
        S_X6: state <= S_X7;
        S_X7: state <= S_INC;
        S_INC: begin
          cu_n  <= moved ? pb : un;
          steps <= steps + LINK_W'(1);
          state <= S_CU0;
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            path_chunk <= rev64(path[CHUNK_W-1:0]);
            chunk_bits <= (plen > PLEN_W'(CHUNK_W)) ? 7'd64 : plen[6:0];
            last_chunk <= (plen <= PLEN_W'(CHUNK_W));
            path       <= path >> CHUNK_W;
            plen       <= (plen > PLEN_W'(CHUNK_W)) ? plen - PLEN_W'(CHUNK_W) : '0;
            if (plen <= PLEN_W'(CHUNK_W)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AHTU_ASSERT_IMPL(a_used_odd, clk, rst, 1'b1, nodes_used[0])
  `AHTU_ASSERT_IMPL(a_used_max, clk, rst, 1'b1, nodes_used <= MAXN)
  `AHTU_ASSERT_IMPL(a_esc_used, clk, rst, state != S_SPL3, esc < nodes_used)
  `AHTU_ASSERT_IMPL(a_more_chunks, clk, rst, out_valid && !last_chunk, state == S_EMIT)
  `AHTU_ASSERT_NEXT(a_done_idle, clk, rst, emit_fire && plen <= PLEN_W'(CHUNK_W), state == S_IDLE)

endmodule

`default_nettype wire
